// ----- rtl/dspc_pkg.sv -----
package dspc_pkg;

	localparam int TEMP_BITS_DEF  = 12;
	localparam int COUNT_BITS_DEF = 18;

	// Fixed register widths
	localparam int LEVEL_BITS  = 12;
	localparam int TARGET_BITS = 11;
	localparam int INDEX_BITS  = 3;

	// Register reset values
	localparam int OVERHEAT_ON_RESET  = 720;
	localparam int OVERHEAT_OFF_RESET = 608;
	localparam int DIFF_ON_RESET      = 48;
	localparam int DIFF_OFF_RESET     = 16;
	localparam int TARGET_RESET       = 416;
	localparam int IDLE_RESET         = 10000;
	localparam int HOLD_RESET         = 200000;

	// Target limits, in 1/16 degree
	localparam int TARGET_MAX  = 1600;
	localparam int TARGET_STEP = 8;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LEFT  = 2'd1,
		OP_RIGHT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_ENABLED  = 2'd0,
		MODE_OVERHEAT = 2'd1,
		MODE_NODIFF   = 2'd2
	} mode_t;

	typedef enum logic [INDEX_BITS-1:0] {
		REG_OVERHEAT_ON  = 3'd0,
		REG_OVERHEAT_OFF = 3'd1,
		REG_DIFF_ON      = 3'd2,
		REG_DIFF_OFF     = 3'd3,
		REG_TARGET_RESET = 3'd4,
		REG_IDLE_PERIOD  = 3'd5,
		REG_HOLD_PERIOD  = 3'd6
	} reg_idx_t;

	function automatic int cfg_bits(input int temp_bits, input int count_bits);
		int w;
		w = LEVEL_BITS;
		if (temp_bits > w) w = temp_bits;
		if (count_bits > w) w = count_bits;
		return w;
	endfunction

	function automatic int byte_round(input int bits);
		return ((bits + 7) / 8) * 8;
	endfunction

endpackage

// ----- rtl/differential_solar_pump_controller_unit.sv -----
// Throughput: one transaction per cycle while s_axis_tready is high.
// All rules are evaluated in a single registered pass.
// A two-entry output buffer keeps the slave side ready for one more transaction while a
// result waits to be taken; s_axis_tready falls only when both entries are full.
// arst_n (asynchronous, active low) restores every configuration register to its default,
// sets the controller to enabled, control mode, target 26 degrees, and empties the buffer.
module differential_solar_pump_controller_unit #(
	parameter int TEMP_BITS  = dspc_pkg::TEMP_BITS_DEF,
	parameter int COUNT_BITS = dspc_pkg::COUNT_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_wr_en,
	input  logic [dspc_pkg::INDEX_BITS-1:0]               cfg_index,
	input  logic [dspc_pkg::cfg_bits(TEMP_BITS, COUNT_BITS)-1:0] cfg_data,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// collector_temp, water_temp
	input  logic [dspc_pkg::byte_round(2*TEMP_BITS)-1:0]  s_axis_tdata,
	// op
	input  logic [1:0]                                    s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// pump_on, shown_temp, heating_flag, overheat_flag, no_difference_flag,
	// circuit_enabled_flag, setting_mode_flag, zero fill
	output logic [dspc_pkg::byte_round(TEMP_BITS+6)-1:0]  m_axis_tdata
);
	import dspc_pkg::*;

	localparam int RES_BITS = TEMP_BITS + 6;
	localparam int OUT_BITS = byte_round(RES_BITS);

	logic signed [TEMP_BITS-1:0]  overheat_on_q, overheat_off_q;
	logic [LEVEL_BITS-1:0]        diff_on_q, diff_off_q;
	logic [COUNT_BITS-1:0]        idle_period_q, hold_period_q;

	logic                         accept, take;
	logic [RES_BITS-1:0]          result;
	logic                         out_valid_q, skid_valid_q;
	logic [RES_BITS-1:0]          out_data_q, skid_data_q;

	// The target reset level only matters at reset, where its default applies,
	// so that register is not stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overheat_on_q  <= TEMP_BITS'(OVERHEAT_ON_RESET);
			overheat_off_q <= TEMP_BITS'(OVERHEAT_OFF_RESET);
			diff_on_q      <= LEVEL_BITS'(DIFF_ON_RESET);
			diff_off_q     <= LEVEL_BITS'(DIFF_OFF_RESET);
			idle_period_q  <= COUNT_BITS'(IDLE_RESET);
			hold_period_q  <= COUNT_BITS'(HOLD_RESET);
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OVERHEAT_ON:  overheat_on_q  <= cfg_data[TEMP_BITS-1:0];
				REG_OVERHEAT_OFF: overheat_off_q <= cfg_data[TEMP_BITS-1:0];
				REG_DIFF_ON:      diff_on_q      <= cfg_data[LEVEL_BITS-1:0];
				REG_DIFF_OFF:     diff_off_q     <= cfg_data[LEVEL_BITS-1:0];
				REG_IDLE_PERIOD:  idle_period_q  <= cfg_data[COUNT_BITS-1:0];
				REG_HOLD_PERIOD:  hold_period_q  <= cfg_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = !skid_valid_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign take   = out_valid_q && m_axis_tready;

	dspc_core #(
		.TEMP_BITS  (TEMP_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.accept              (accept),
		.op                  (op_t'(s_axis_tuser)),
		.collector_temp      (s_axis_tdata[TEMP_BITS-1:0]),
		.water_temp          (s_axis_tdata[2*TEMP_BITS-1:TEMP_BITS]),
		.overheat_on_level   (overheat_on_q),
		.overheat_off_level  (overheat_off_q),
		.diff_on_level       (diff_on_q),
		.diff_off_level      (diff_off_q),
		.idle_period         (idle_period_q),
		.setting_hold_period (hold_period_q),
		.result              (result)
	);

	// Output register plus one skid entry; results leave in acceptance order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else if (!accept)
				out_valid_q <= 1'b0;
		end else if (accept) begin
			if (!out_valid_q)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q)
				out_data_q <= skid_data_q;
			else if (accept)
				out_data_q <= result;
		end else if (accept) begin
			if (!out_valid_q)
				out_data_q <= result;
			else
				skid_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_BITS'(out_data_q);

endmodule

// ----- rtl/dspc_core.sv -----
module dspc_core #(
	parameter int TEMP_BITS  = dspc_pkg::TEMP_BITS_DEF,
	parameter int COUNT_BITS = dspc_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  dspc_pkg::op_t                 op,
	input  logic signed [TEMP_BITS-1:0]   collector_temp,
	input  logic signed [TEMP_BITS-1:0]   water_temp,
	input  logic signed [TEMP_BITS-1:0]   overheat_on_level,
	input  logic signed [TEMP_BITS-1:0]   overheat_off_level,
	input  logic [dspc_pkg::LEVEL_BITS-1:0] diff_on_level,
	input  logic [dspc_pkg::LEVEL_BITS-1:0] diff_off_level,
	input  logic [COUNT_BITS-1:0]         idle_period,
	input  logic [COUNT_BITS-1:0]         setting_hold_period,
	output logic [TEMP_BITS+5:0]          result
);
	import dspc_pkg::*;

	// Difference of two samples, and a width where unsigned levels compare as signed.
	localparam int DIFF_BITS = (TEMP_BITS + 1 > LEVEL_BITS + 1) ? TEMP_BITS + 1 : LEVEL_BITS + 1;
	localparam int CMP_BITS  = (TEMP_BITS > TARGET_BITS + 1) ? TEMP_BITS : TARGET_BITS + 1;

	mode_t                        mode_q, mode_d, rule_mode;
	logic                         heating_q, heating_d;
	logic                         setting_q, setting_d;
	logic                         show_coll_q, show_coll_d;
	logic [TARGET_BITS-1:0]       target_q, target_d;
	logic signed [TEMP_BITS-1:0]  samp_coll_q, samp_coll_d;
	logic signed [TEMP_BITS-1:0]  samp_water_q, samp_water_d;
	logic [COUNT_BITS-1:0]        countdown_q, countdown_d;

	logic signed [DIFF_BITS-1:0]  diff;
	logic signed [DIFF_BITS-1:0]  diff_on_ext, diff_off_ext;
	logic signed [CMP_BITS-1:0]   water_ext, target_ext;
	logic [TARGET_BITS:0]         target_up;
	logic                         timeout;
	logic signed [TEMP_BITS-1:0]  shown;

	assign timeout = (countdown_q == '0);

	// Hysteresis rules evaluated on the incoming readings, used only on a timeout.
	assign diff = DIFF_BITS'(collector_temp) - DIFF_BITS'(water_temp);
	assign diff_on_ext  = DIFF_BITS'({1'b0, diff_on_level});
	assign diff_off_ext = DIFF_BITS'({1'b0, diff_off_level});
	assign water_ext  = CMP_BITS'(water_temp);
	assign target_ext = CMP_BITS'({1'b0, target_q});
	assign target_up  = {1'b0, target_q} + (TARGET_BITS+1)'(TARGET_STEP);

	always_comb begin
		rule_mode = mode_q;
		if (collector_temp > overheat_on_level) rule_mode = MODE_OVERHEAT;
		if (diff < diff_off_ext) rule_mode = MODE_NODIFF;
		if (rule_mode == MODE_OVERHEAT && collector_temp < overheat_off_level)
			rule_mode = MODE_ENABLED;
		if (rule_mode == MODE_NODIFF && diff > diff_on_ext)
			rule_mode = MODE_ENABLED;
	end

	always_comb begin
		mode_d       = mode_q;
		heating_d    = heating_q;
		setting_d    = setting_q;
		show_coll_d  = show_coll_q;
		target_d     = target_q;
		samp_coll_d  = samp_coll_q;
		samp_water_d = samp_water_q;
		countdown_d  = countdown_q;
		case (op)
			OP_TICK: begin
				if (timeout) begin
					setting_d    = 1'b0;
					samp_coll_d  = collector_temp;
					samp_water_d = water_temp;
					mode_d       = rule_mode;
					// The two heating rules together reduce to a plain compare.
					heating_d    = (water_ext < target_ext);
					countdown_d  = idle_period;
				end else begin
					countdown_d = countdown_q - COUNT_BITS'(1);
				end
			end
			OP_LEFT: begin
				if (!setting_q) begin
					setting_d = 1'b1;
				end else if (target_q < TARGET_BITS'(TARGET_STEP)) begin
					target_d = '0;
				end else begin
					target_d = target_q - TARGET_BITS'(TARGET_STEP);
				end
				countdown_d = setting_hold_period;
			end
			OP_RIGHT: begin
				if (!setting_q) begin
					show_coll_d = !show_coll_q;
				end else begin
					countdown_d = setting_hold_period;
					if (target_up > (TARGET_BITS+1)'(TARGET_MAX))
						target_d = TARGET_BITS'(TARGET_MAX);
					else
						target_d = target_up[TARGET_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ENABLED;
			heating_q    <= 1'b0;
			setting_q    <= 1'b0;
			show_coll_q  <= 1'b0;
			target_q     <= TARGET_BITS'(TARGET_RESET);
			samp_coll_q  <= '0;
			samp_water_q <= '0;
			countdown_q  <= COUNT_BITS'(IDLE_RESET);
		end else if (accept) begin
			mode_q       <= mode_d;
			heating_q    <= heating_d;
			setting_q    <= setting_d;
			show_coll_q  <= show_coll_d;
			target_q     <= target_d;
			samp_coll_q  <= samp_coll_d;
			samp_water_q <= samp_water_d;
			countdown_q  <= countdown_d;
		end
	end

	// The result reflects the state after this transaction.
	always_comb begin
		if (setting_d)
			shown = TEMP_BITS'(target_d);
		else if (show_coll_d)
			shown = samp_coll_d;
		else
			shown = samp_water_d;
	end

	assign result = {setting_d,
	                 mode_d == MODE_ENABLED,
	                 mode_d == MODE_NODIFF,
	                 mode_d == MODE_OVERHEAT,
	                 heating_d,
	                 shown,
	                 (mode_d == MODE_ENABLED) && heating_d};

endmodule

// ----- rtl/dspc_checker.sv -----
module dspc_checker #(
	parameter int TEMP_BITS  = dspc_pkg::TEMP_BITS_DEF,
	parameter int COUNT_BITS = dspc_pkg::COUNT_BITS_DEF
) (
	input logic                                          clk,
	input logic                                          arst_n,
	input logic                                          cfg_wr_en,
	input logic [dspc_pkg::INDEX_BITS-1:0]               cfg_index,
	input logic [dspc_pkg::cfg_bits(TEMP_BITS, COUNT_BITS)-1:0] cfg_data,
	input logic                                          s_axis_tvalid,
	input logic                                          s_axis_tready,
	input logic [dspc_pkg::byte_round(2*TEMP_BITS)-1:0]  s_axis_tdata,
	input logic [1:0]                                    s_axis_tuser,
	input logic                                          m_axis_tvalid,
	input logic                                          m_axis_tready,
	input logic [dspc_pkg::byte_round(TEMP_BITS+6)-1:0]  m_axis_tdata
);
	import dspc_pkg::*;

	logic pump, heating, overheat, nodiff, enabled;

	assign pump     = m_axis_tdata[0];
	assign heating  = m_axis_tdata[TEMP_BITS+1];
	assign overheat = m_axis_tdata[TEMP_BITS+2];
	assign nodiff   = m_axis_tdata[TEMP_BITS+3];
	assign enabled  = m_axis_tdata[TEMP_BITS+4];

	// The pump only runs with the circuit enabled and heating requested.
	a_pump_rule: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!pump || (heating && enabled)))
		else $error("pump_on without enabled circuit and heating");

	// The circuit is always in exactly one of its three modes.
	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot({overheat, nodiff, enabled}))
		else $error("circuit mode flags are not one-hot");

	// Backpressure reaches the slave side only when a result is pending.
	a_ready_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// An accepted transaction with an idle master side produces a result next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> m_axis_tvalid)
		else $error("result missing one cycle after transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind differential_solar_pump_controller_unit dspc_checker #(
	.TEMP_BITS  (TEMP_BITS),
	.COUNT_BITS (COUNT_BITS)
) u_dspc_checker (.*);
